/* rtl/core/swls_pkg.sv */
// Shared types and constants for the stack with linear search.
// No dependencies; imported by the cell, the controller and the top level.
`timescale 1ns / 1ps

package swls_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int POS_W           = 5;

	// Command broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic push;    // shift the chain down, new word enters the top cell
		logic pop;     // shift the chain up
		logic rotate;  // rotate the occupied cells up by one, top goes to the bottom
	} cell_cmd_t;

endpackage

/* rtl/core/swls_cell.sv */
// One storage cell of the stack chain; cell 0 holds the top of stack.
// Depends on swls_pkg for the command struct and data width.
`timescale 1ns / 1ps

module swls_cell
	import swls_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int IDX         = 0
) (
	input  logic                                 clk,
	input  cell_cmd_t                            cmd,
	input  logic [$clog2(STACK_DEPTH + 1)-1:0]  count,
	input  logic [DATA_W-1:0]                    up_data,
	input  logic [DATA_W-1:0]                    dn_data,
	input  logic [DATA_W-1:0]                    top_data,
	output logic [DATA_W-1:0]                    data_q
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX + 1);

	// Payload only: entries are never read before they are written.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			data_q <= up_data;
		end else if (cmd.pop) begin
			data_q <= dn_data;
		end else if (cmd.rotate) begin
			if (count == MY_CNT) begin
				data_q <= top_data;
			end else if (MY_CNT < count) begin
				data_q <= dn_data;
			end
		end
	end

endmodule

/* rtl/core/swls_ctrl.sv */
// Sequencer for the stack: fill count, operation decode, walk counter
// and the output register. Depends on swls_pkg; drives the cell chain.
`timescale 1ns / 1ps

module swls_ctrl
	import swls_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          in_op,
	input  logic [DATA_W-1:0]                   in_value,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [1:0]                          out_status,
	output logic [DATA_W-1:0]                   out_item,
	output logic [POS_W-1:0]                    out_pos,
	output logic                                out_last,
	input  logic [DATA_W-1:0]                   top_data,
	output cell_cmd_t                           cmd,
	output logic [DATA_W-1:0]                   push_data,
	output logic [$clog2(STACK_DEPTH + 1)-1:0] count
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;
	localparam logic [1:0] OP_LIST   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_REPORT = 2'd2;

	logic [1:0]        state_q, state_nxt;
	logic [1:0]        op_q;
	logic [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]  count_q, count_nxt;
	logic [CNT_W-1:0]  walk_q, walk_nxt;
	logic              found_q, found_nxt;
	logic [POS_W-1:0]  hit_q, hit_nxt;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [DATA_W-1:0] out_item_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit;
	logic [1:0]        e_status;
	logic [DATA_W-1:0] e_item;
	logic [POS_W-1:0]  e_pos;
	logic              e_last;
	logic              is_empty, is_full, walk_end;
	logic [POS_W-1:0]  walk_pos;

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == FULL_CNT);
	assign walk_end  = (walk_q == count_q - CNT_W'(1));
	assign walk_pos  = POS_W'({1'b0, walk_q} + {{CNT_W{1'b0}}, 1'b1});
	assign push_data = key_q;
	assign count     = count_q;

	always_comb begin
		state_nxt = state_q;
		count_nxt = count_q;
		walk_nxt  = walk_q;
		found_nxt = found_q;
		hit_nxt   = hit_q;
		cmd       = '0;
		emit      = 1'b0;
		e_status  = ST_OK;
		e_item    = '0;
		e_pos     = '0;
		e_last    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				walk_nxt  = '0;
				found_nxt = 1'b0;
				hit_nxt   = '0;
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (op_q)
					OP_PUSH: begin
						if (out_free) begin
							emit      = 1'b1;
							state_nxt = S_IDLE;
							if (is_full) begin
								e_status = ST_FULL;
							end else begin
								cmd.push  = 1'b1;
								count_nxt = count_q + CNT_W'(1);
							end
						end
					end
					OP_POP: begin
						if (out_free) begin
							emit      = 1'b1;
							state_nxt = S_IDLE;
							if (is_empty) begin
								e_status = ST_EMPTY;
							end else begin
								e_item    = top_data;
								cmd.pop   = 1'b1;
								count_nxt = count_q - CNT_W'(1);
							end
						end
					end
					OP_SEARCH: begin
						if (is_empty) begin
							if (out_free) begin
								emit      = 1'b1;
								e_status  = ST_EMPTY;
								state_nxt = S_IDLE;
							end
						end else begin
							// The walk always runs over every stored word so the chain ends
							// in its original order.
							cmd.rotate = 1'b1;
							if (!found_q && (top_data == key_q)) begin
								found_nxt = 1'b1;
								hit_nxt   = walk_pos;
							end
							if (walk_end) begin
								state_nxt = S_REPORT;
							end else begin
								walk_nxt = walk_q + CNT_W'(1);
							end
						end
					end
					OP_LIST: begin
						if (out_free) begin
							if (is_empty) begin
								emit      = 1'b1;
								e_status  = ST_EMPTY;
								state_nxt = S_IDLE;
							end else begin
								emit       = 1'b1;
								e_item     = top_data;
								e_pos      = walk_pos;
								e_last     = walk_end;
								cmd.rotate = 1'b1;
								if (walk_end) begin
									state_nxt = S_IDLE;
								end else begin
									walk_nxt = walk_q + CNT_W'(1);
								end
							end
						end
					end
					default: ;
				endcase
			end
			S_REPORT: begin
				if (out_free) begin
					emit      = 1'b1;
					state_nxt = S_IDLE;
					if (found_q) begin
						e_pos = hit_q;
					end else begin
						e_status = ST_NOTFOUND;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			walk_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			walk_q  <= walk_nxt;
			found_q <= found_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit_nxt;
		if (in_valid && in_ready) begin
			op_q  <= in_op;
			key_q <= in_value;
		end
		if (emit) begin
			out_status_q <= e_status;
			out_item_q   <= e_item;
			out_pos_q    <= e_pos;
			out_last_q   <= e_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_item   = out_item_q;
	assign out_pos    = out_pos_q;
	assign out_last   = out_last_q;

endmodule

/* rtl/core/stack_with_linear_search_unit.sv */
// Top level of the stack with linear search: controller plus a chain of cells.
// Depends on swls_pkg, swls_ctrl and swls_cell.
//
//   channel | beat fields                                      | accepted when
//   --------+--------------------------------------------------+-------------------
//   s_*     | tuser: operation; tdata: value                   | s_tvalid & s_tready
//   m_*     | tuser: status; tdata: item, position; tlast      | m_tvalid & m_tready
//
// Push and pop accept the beat in the idle state and write the result from the
// execute state. Search walks the n stored words, one per cycle, by rotating the
// chain, then reports; a list gives one result beat per cycle while output is free.
// Reset clears the fill count and the control state; cell contents are left as they are.
// A result waiting in the output register does not block acceptance of the next
// input beat; while it waits with m_tready low, the next result and a list walk stall.
`timescale 1ns / 1ps

module stack_with_linear_search_unit
	import swls_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] item, [36:32] position, [39:37] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	cell_cmd_t         cmd;
	logic [DATA_W-1:0] push_data;
	logic [CNT_W-1:0]  count;
	logic [DATA_W-1:0] cell_data [STACK_DEPTH];
	logic [DATA_W-1:0] item;
	logic [POS_W-1:0]  position;

	swls_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_value  (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_status(m_tuser),
		.out_item  (item),
		.out_pos   (position),
		.out_last  (m_tlast),
		.top_data  (cell_data[0]),
		.cmd       (cmd),
		.push_data (push_data),
		.count     (count)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] up_data;
		logic [DATA_W-1:0] dn_data;

		if (i == 0) begin : g_top
			assign up_data = push_data;
		end else begin : g_mid
			assign up_data = cell_data[i-1];
		end

		// The bottom cell has no neighbor below; on pop it keeps its word.
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign dn_data = cell_data[i];
		end else begin : g_up
			assign dn_data = cell_data[i+1];
		end

		swls_cell #(
			.STACK_DEPTH(STACK_DEPTH),
			.IDX        (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.count   (count),
			.up_data (up_data),
			.dn_data (dn_data),
			.top_data(cell_data[0]),
			.data_q  (cell_data[i])
		);
	end

	assign m_tdata = {3'b000, position, item};

endmodule
